### hdl/prime_position_lsb_extractor_core_defines.svh
// ----------------------------------------------------------------------------
// Prime Position LSB Extractor - Assertion Macros
// Shared property wrappers for the checker, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PRIME_POSITION_LSB_EXTRACTOR_CORE_DEFINES_SVH
`define PRIME_POSITION_LSB_EXTRACTOR_CORE_DEFINES_SVH

// same-cycle implication
`define PPLE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("property violated");

// next-cycle implication
`define PPLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("property violated");

`endif

### hdl/pple_pkg.sv
// ----------------------------------------------------------------------------
// Prime Position LSB Extractor - Package
// Shared constants, status codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pple_pkg;

    localparam int CHAR_BITS   = 8;
    localparam int CNT_BITS    = $clog2(CHAR_BITS);
    localparam int START_BITS  = 10;
    localparam int STATUS_BITS = 2;

    localparam logic [START_BITS-1:0] START_RESET = 10'd23;

    localparam logic [STATUS_BITS-1:0] STAT_CHAR  = 2'd0;
    localparam logic [STATUS_BITS-1:0] STAT_TERM  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STAT_ERROR = 2'd2;

    typedef struct packed {
        logic load;
        logic eval;
        logic set_prime;
        logic div_start;
        logic next_divisor;
        logic commit;
    } pple_cmd_t;

    typedef struct packed {
        logic done;
        logic quick;
        logic sq_over;
        logic div_done;
        logic rem_zero;
        logic emit;
        logic slot_free;
    } pple_sts_t;

endpackage

### hdl/pple_divider.sv
// ----------------------------------------------------------------------------
// Prime Position LSB Extractor - Remainder Unit
// Bit-serial restoring remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module pple_divider #(
    parameter int DIVIDEND_BITS = 24,
    parameter int DIVISOR_BITS  = 13
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic                     done,
    output logic                     rem_zero
);

    localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  rem_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [DIVISOR_BITS:0]    rem_sh;
    logic [DIVISOR_BITS:0]    divisor_ext;
    logic [DIVISOR_BITS:0]    rem_diff;

    assign rem_sh      = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
    assign divisor_ext = {1'b0, divisor};
    assign rem_diff    = rem_sh - divisor_ext;

    always_comb
    begin
        if (rem_sh >= divisor_ext)
        begin
            rem_next = rem_diff[DIVISOR_BITS-1:0];
        end
        else
        begin
            rem_next = rem_sh[DIVISOR_BITS-1:0];
        end
    end

    assign done     = (cnt_reg == '0);
    assign rem_zero = (rem_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(DIVIDEND_BITS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DIVIDEND_BITS-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

endmodule

### hdl/pple_datapath.sv
// ----------------------------------------------------------------------------
// Prime Position LSB Extractor - Datapath
// Position counter, trial divisor and square, character packer,
// start index register and output register.
// ----------------------------------------------------------------------------
module pple_datapath #(
    parameter int POSITION_BITS = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  pple_pkg::pple_cmd_t                    cmd,
    output pple_pkg::pple_sts_t                    sts,
    input  logic                                   first_byte,
    input  logic                                   last_byte,
    input  logic                                   pixel_lsb,
    input  logic                                   cfg_wr_en,
    input  logic [pple_pkg::START_BITS-1:0]        cfg_wr_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [pple_pkg::CHAR_BITS-1:0]         message_char,
    output logic [pple_pkg::STATUS_BITS-1:0]       status
);

    import pple_pkg::*;

    localparam int DIV_BITS = (POSITION_BITS + 1) / 2 + 1;
    localparam int SQ_BITS  = 2 * DIV_BITS;
    localparam int CMP_BITS = (POSITION_BITS > START_BITS) ? POSITION_BITS : START_BITS;
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] n_reg;
    logic [CNT_BITS-1:0]      bit_cnt_reg;
    logic [CHAR_BITS-1:0]     acc_reg;
    logic                     done_reg;
    logic                     prime_reg;
    logic                     last_reg;
    logic                     lsb_reg;
    logic [DIV_BITS-1:0]      d_reg;
    logic [SQ_BITS-1:0]       sq_reg;
    logic [START_BITS-1:0]    start_reg;
    logic                     out_valid_reg;
    logic [CHAR_BITS-1:0]     out_char_reg;
    logic [STATUS_BITS-1:0]   out_status_reg;

    logic                     eligible;
    logic [CHAR_BITS-1:0]     acc_next;
    logic                     have_char;
    logic                     term;
    logic                     emit;
    logic                     div_done;
    logic                     rem_zero;

    pple_divider #(
        .DIVIDEND_BITS (POSITION_BITS),
        .DIVISOR_BITS  (DIV_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (n_reg),
        .divisor  (d_reg),
        .done     (div_done),
        .rem_zero (rem_zero)
    );

    assign eligible = (pos_reg != POS_MAX)
                   && (CMP_BITS'(pos_reg) >= CMP_BITS'(start_reg))
                   && (pos_reg >= POSITION_BITS'(2));

    assign acc_next  = acc_reg | (CHAR_BITS'(lsb_reg & prime_reg) << bit_cnt_reg);
    assign have_char = prime_reg && (bit_cnt_reg == CNT_BITS'(CHAR_BITS - 1));
    assign term      = have_char && (acc_next == '0);
    assign emit      = term || last_reg || have_char;

    assign sts.done      = done_reg;
    assign sts.quick     = !eligible || (pos_reg == POSITION_BITS'(2)) || !pos_reg[0];
    assign sts.sq_over   = sq_reg > SQ_BITS'(n_reg);
    assign sts.div_done  = div_done;
    assign sts.rem_zero  = rem_zero;
    assign sts.emit      = emit;
    assign sts.slot_free = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign message_char = out_char_reg;
    assign status       = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            bit_cnt_reg   <= '0;
            acc_reg       <= '0;
            done_reg      <= 1'b0;
            prime_reg     <= 1'b0;
            start_reg     <= START_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                start_reg <= cfg_wr_data;
            end

            if (cmd.load && first_byte)
            begin
                pos_reg     <= '0;
                bit_cnt_reg <= '0;
                acc_reg     <= '0;
                done_reg    <= 1'b0;
            end

            if (cmd.eval)
            begin
                prime_reg <= (pos_reg == POSITION_BITS'(2)) && eligible;
                if (pos_reg != POS_MAX)
                begin
                    pos_reg <= pos_reg + POSITION_BITS'(1);
                end
            end

            if (cmd.set_prime)
            begin
                prime_reg <= 1'b1;
            end

            if (cmd.commit)
            begin
                if (prime_reg)
                begin
                    if (have_char)
                    begin
                        bit_cnt_reg <= '0;
                        acc_reg     <= '0;
                    end
                    else
                    begin
                        bit_cnt_reg <= bit_cnt_reg + CNT_BITS'(1);
                        acc_reg     <= acc_next;
                    end
                end
                if (term || last_reg)
                begin
                    done_reg <= 1'b1;
                end
            end

            if (cmd.commit && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            last_reg <= last_byte;
            lsb_reg  <= pixel_lsb;
        end

        if (cmd.eval)
        begin
            n_reg  <= pos_reg;
            d_reg  <= DIV_BITS'(3);
            sq_reg <= SQ_BITS'(9);
        end
        else if (cmd.next_divisor)
        begin
            d_reg  <= d_reg + DIV_BITS'(2);
            sq_reg <= sq_reg + SQ_BITS'({d_reg, 2'b00}) + SQ_BITS'(4);
        end

        if (cmd.commit && emit)
        begin
            priority if (term)
            begin
                out_char_reg   <= '0;
                out_status_reg <= STAT_TERM;
            end
            else if (last_reg)
            begin
                out_char_reg   <= '0;
                out_status_reg <= STAT_ERROR;
            end
            else
            begin
                out_char_reg   <= acc_next;
                out_status_reg <= STAT_CHAR;
            end
        end
    end

endmodule

### hdl/pple_ctrl.sv
// ----------------------------------------------------------------------------
// Prime Position LSB Extractor - Controller
// Sequences input capture, primality trial loop and result commit.
// ----------------------------------------------------------------------------
module pple_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pple_pkg::pple_sts_t sts,
    output pple_pkg::pple_cmd_t cmd
);

    import pple_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_CHECK,
        S_DIVIDE,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (sts.done)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.eval   = 1'b1;
                    state_next = sts.quick ? S_FINISH : S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.sq_over)
                begin
                    cmd.set_prime = 1'b1;
                    state_next    = S_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                if (sts.div_done)
                begin
                    if (sts.rem_zero)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.next_divisor = 1'b1;
                        state_next       = S_CHECK;
                    end
                end
            end
            S_FINISH:
            begin
                if (!sts.emit || sts.slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/prime_position_lsb_extractor_core.sv
// ----------------------------------------------------------------------------
// Prime Position LSB Extractor - Top Level
// Recovers a message hidden in the lowest bits of image bytes whose
// positions are prime and not below start_index.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one image byte per transaction with
// first_byte and last_byte marks. Output channel (out_valid/out_ready) carries
// message_char and status: ordinary character, terminator, or image ended
// without terminator. cfg_wr_en/cfg_wr_data write start_index; the user writes
// it only while idle, which the block does not enforce. One byte is processed at
// a time. A byte needing no primality test passes the evaluate and finish steps
// before it is ready again (the evaluate step alone once the message is done).
// An odd eligible position n runs a trial loop over odd divisors d with d*d <= n;
// each divisor takes a check step and a pass of the bit-serial remainder unit.
// A result is registered at the end of the final step and is held in the output
// register until taken; the next byte is accepted meanwhile, and its own
// result waits in the final step only while the output register is still full.
// Reset clears position, character state and the done flag, empties the
// output register and sets start_index to 23.
// ----------------------------------------------------------------------------
module prime_position_lsb_extractor_core #(
    parameter int POSITION_BITS = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               first_byte,
    input  logic                               last_byte,
    input  logic [7:0]                         pixel_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [pple_pkg::CHAR_BITS-1:0]     message_char,
    output logic [pple_pkg::STATUS_BITS-1:0]   status,
    input  logic                               cfg_wr_en,
    input  logic [pple_pkg::START_BITS-1:0]    cfg_wr_data
);

    import pple_pkg::*;

    pple_cmd_t cmd;
    pple_sts_t sts;

    pple_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pple_datapath #(
        .POSITION_BITS (POSITION_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .first_byte   (first_byte),
        .last_byte    (last_byte),
        .pixel_lsb    (pixel_byte[0]),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .message_char (message_char),
        .status       (status)
    );

endmodule

### hdl/pple_checker.sv
// ----------------------------------------------------------------------------
// Prime Position LSB Extractor - Port Checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "prime_position_lsb_extractor_core_defines.svh"

module pple_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [pple_pkg::CHAR_BITS-1:0]     message_char,
    input logic [pple_pkg::STATUS_BITS-1:0]   status
);

    import pple_pkg::*;

    `PPLE_ASSERT_SAME(a_status_code, out_valid, status <= STAT_ERROR)

    `PPLE_ASSERT_SAME(a_zero_char_on_end, out_valid && (status != STAT_CHAR), message_char == '0)

    `PPLE_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

    `PPLE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(message_char) && $stable(status))

endmodule

bind prime_position_lsb_extractor_core pple_checker u_checker (.*);

### test/prime_position_lsb_extractor_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Prime Position LSB Extractor - Testbench
// Sends image bytes through the input channel and checks every decoded
// character, terminator and unterminated-image result against a byte-level
// decoder kept in the testbench. Covers images with no leading first_byte,
// bytes after the message has ended, terminators and characters completed on
// the last byte, start_index at 0, 23 and 1023, long output back-pressure and
// random images under several idle and stall mixes.
// ----------------------------------------------------------------------------
module prime_position_lsb_extractor_core_test;

    import pple_pkg::*;

    localparam int SETTLE_CYCLES  = 500;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT    = 8000;

    typedef struct {
        logic [CHAR_BITS-1:0]   chr;
        logic [STATUS_BITS-1:0] stat;
    } decoded_t;

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   in_valid     = 1'b0;
    logic                   in_ready;
    logic                   first_byte   = 1'b0;
    logic                   last_byte    = 1'b0;
    logic [7:0]             pixel_byte   = 8'h00;
    logic                   out_valid;
    logic                   out_ready    = 1'b0;
    logic [CHAR_BITS-1:0]   message_char;
    logic [STATUS_BITS-1:0] status;
    logic                   cfg_wr_en    = 1'b0;
    logic [START_BITS-1:0]  cfg_wr_data  = '0;

    // decoder state mirrored in the testbench
    bit [START_BITS-1:0] start_now    = START_RESET;
    bit [23:0]           byte_pos     = '0;
    bit [2:0]            bits_held    = '0;
    bit [CHAR_BITS-1:0]  partial_char = '0;
    bit                  message_over = 1'b0;

    decoded_t pending_chars[$];

    int tx_idle_pct       = 0;
    int rx_stall_pct      = 0;
    int hold_requests     = 0;
    int holds_taken       = 0;
    int hold_left         = 0;
    int idle_cycles       = 0;
    int mismatches        = 0;
    int bytes_sent        = 0;
    int bytes_decoded     = 0;
    int images_started    = 0;
    int results_predicted = 0;
    int chars_expected    = 0;
    int terms_expected    = 0;
    int errors_expected   = 0;

    prime_position_lsb_extractor_core #(
        .POSITION_BITS(24)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .first_byte  (first_byte),
        .last_byte   (last_byte),
        .pixel_byte  (pixel_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .message_char(message_char),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic bit is_prime(input int unsigned n);
        if (n < 2)
            return 1'b0;
        if (n == 2)
            return 1'b1;
        if (n[0] == 1'b0)
            return 1'b0;
        for (int unsigned d = 3; d * d <= n; d += 2)
            if (n % d == 0)
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void push_result(input bit [CHAR_BITS-1:0] chr,
                                        input bit [STATUS_BITS-1:0] stat);
        decoded_t res;
        res.chr  = chr;
        res.stat = stat;
        pending_chars.push_back(res);
        results_predicted++;
    endfunction

    function automatic void decode_byte(input bit is_first, input bit is_last,
                                        input bit [7:0] pixel);
        bit [23:0]          cur;
        bit                 have_char;
        bit [CHAR_BITS-1:0] chr;
        have_char = 1'b0;
        chr       = '0;
        if (is_first)
        begin
            byte_pos     = '0;
            bits_held    = '0;
            partial_char = '0;
            message_over = 1'b0;
            images_started++;
        end
        if (message_over)
            return;
        bytes_decoded++;
        cur = byte_pos;
        if (byte_pos != '1)
            byte_pos = byte_pos + 1'b1;
        if (cur != '1 && cur >= start_now && is_prime(cur))
        begin
            partial_char = partial_char | (CHAR_BITS'(pixel[0]) << bits_held);
            if (bits_held == 3'd7)
            begin
                have_char    = 1'b1;
                chr          = partial_char;
                bits_held    = '0;
                partial_char = '0;
            end
            else
                bits_held = bits_held + 1'b1;
        end
        if (have_char && chr == '0)
        begin
            message_over = 1'b1;
            terms_expected++;
            push_result('0, STAT_TERM);
        end
        else if (is_last)
        begin
            message_over = 1'b1;
            errors_expected++;
            push_result('0, STAT_ERROR);
        end
        else if (have_char)
        begin
            chars_expected++;
            push_result(chr, STAT_CHAR);
        end
    endfunction

    task automatic send_byte(input bit is_first, input bit is_last, input bit [7:0] pixel);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
        in_valid   <= 1'b1;
        first_byte <= is_first;
        last_byte  <= is_last;
        pixel_byte <= pixel;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
        decode_byte(is_first, is_last, pixel);
    endtask

    // hide n_chars nonzero characters, optionally a terminator, then tail bytes
    task automatic send_image(input int n_chars, input bit terminated, input int tail);
        bit [7:0] msg[$];
        bit [7:0] pixel;
        int       total;
        int       k;
        int       pos;
        repeat (n_chars)
            msg.push_back(8'($urandom_range(1, 255)));
        if (terminated)
            msg.push_back(8'h00);
        total = msg.size() * 8;
        k     = 0;
        pos   = 0;
        if (total == 0 && tail == 0)
            tail = 1;
        while (k < total)
        begin
            pixel = 8'($urandom_range(0, 255));
            if (pos >= start_now && is_prime(pos))
            begin
                pixel[0] = msg[k / 8][k % 8];
                k++;
            end
            send_byte(pos == 0, k == total && tail == 0, pixel);
            pos++;
        end
        for (int t = 0; t < tail; t++)
        begin
            send_byte(pos == 0, t == tail - 1, 8'($urandom_range(0, 255)));
            pos++;
        end
    endtask

    task automatic send_noise(input int count);
        repeat (count)
            send_byte($urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                      8'($urandom_range(0, 255)));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_chars.size() != 0);
    endtask

    task automatic set_start_index(input bit [START_BITS-1:0] value);
        wait_for_results();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        start_now = value;
    endtask

    task automatic check_result(input logic [CHAR_BITS-1:0] chr,
                                input logic [STATUS_BITS-1:0] stat);
        decoded_t want;
        if (pending_chars.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result: char %02h status %0d", $time, chr, stat);
        end
        else
        begin
            want = pending_chars.pop_front();
            if (chr !== want.chr || stat !== want.stat)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: expected char %02h status %0d, got char %02h status %0d",
                             $time, want.chr, want.stat, chr, stat);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_result(message_char, status);
        if (hold_requests != holds_taken)
        begin
            holds_taken = hold_requests;
            hold_left   = RX_HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // bytes before any first_byte, bytes after the end, single-byte image
    task automatic test_headless_and_ignored();
        send_byte(1'b0, 1'b0, 8'hFF);
        send_byte(1'b0, 1'b1, 8'h00);
        send_byte(1'b0, 1'b0, 8'hA5);
        send_byte(1'b1, 1'b1, 8'h5A);
    endtask

    task automatic test_terminator_on_last_byte();
        set_start_index('0);
        send_image(0, 1'b1, 0);
    endtask

    task automatic test_start_index_max();
        set_start_index('1);
        send_image(0, 1'b0, 3);
    endtask

    task automatic test_output_backpressure();
        wait_for_results();
        hold_requests <= hold_requests + 1;
        repeat (12)
            send_byte(1'b1, 1'b1, 8'($urandom_range(0, 255)));
        wait_for_results();
    endtask

    task automatic test_random_images();
        int tx_pct[4] = '{0, 62, 0, 26};
        int rx_pct[4] = '{0, 0, 62, 26};
        int sent_at;
        int results_at;
        int choice;
        for (int phase = 0; phase < 4; phase++)
        begin
            set_start_index(phase == 0 ? START_RESET : START_BITS'($urandom_range(0, 15)));
            tx_idle_pct = tx_pct[phase];
            rx_stall_pct <= rx_pct[phase];
            sent_at    = bytes_sent;
            results_at = results_predicted;
            while (bytes_sent - sent_at < 35 || results_predicted - results_at < 2)
            begin
                choice = $urandom_range(0, 9);
                if (choice < 5)
                    send_image($urandom_range(0, 1), 1'b1, $urandom_range(0, 4));
                else if (choice < 7)
                    send_image($urandom_range(0, 1), 1'b0, $urandom_range(0, 2));
                else
                    send_noise($urandom_range(1, 12));
            end
        end
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
    endtask

    initial
    begin
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;

        test_headless_and_ignored();
        test_terminator_on_last_byte();
        test_start_index_max();
        test_output_backpressure();
        test_random_images();

        wait_for_results();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (pending_chars.size() != 0)
        begin
            $display("%0d results never arrived", pending_chars.size());
            mismatches += pending_chars.size();
        end

        $display("Decoded %0d bytes over %0d images, start_index at 0, 23, 1023 and random",
                 bytes_decoded, images_started);
        $display("Expected %0d characters, %0d terminators, %0d unterminated; %0d mismatches",
                 chars_expected, terms_expected, errors_expected, mismatches);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/pple_pkg.sv
hdl/pple_divider.sv
hdl/pple_datapath.sv
hdl/pple_ctrl.sv
hdl/prime_position_lsb_extractor_core.sv
hdl/pple_checker.sv
test/prime_position_lsb_extractor_core_test.sv
